// File: hdl/mks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad scanner package
// Phase codes, event kinds, register map and shared types.
// ----------------------------------------------------------------------------
package mks_pkg;

   // scan phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_DEB_IN  = 3'd1;
   localparam logic [2:0] PH_SCAN    = 3'd2;
   localparam logic [2:0] PH_HOLD    = 3'd3;
   localparam logic [2:0] PH_LONG    = 3'd4;
   localparam logic [2:0] PH_DEB_OUT = 3'd5;

   // event kinds
   localparam logic [2:0] EV_PRESSED  = 3'd0;
   localparam logic [2:0] EV_SHORT    = 3'd1;
   localparam logic [2:0] EV_LONG     = 3'd2;
   localparam logic [2:0] EV_REPEAT   = 3'd3;
   localparam logic [2:0] EV_RELEASED = 3'd4;

   // held line codes
   localparam logic [2:0] ROW_IS_PTT    = 3'd4;
   localparam logic [2:0] COL_SIDE_CODE = 3'd7;
   localparam logic [4:0] KEY_PTT       = 5'd20;

   // register indexes (byte address 4*i)
   localparam logic [1:0] REG_DEB_IN  = 2'd0;
   localparam logic [1:0] REG_DEB_OUT = 2'd1;
   localparam logic [1:0] REG_LONG    = 2'd2;
   localparam logic [1:0] REG_REPEAT  = 2'd3;

   localparam logic [15:0] DEB_IN_RESET  = 16'd30;
   localparam logic [15:0] DEB_OUT_RESET = 16'd30;
   localparam logic [15:0] LONG_RESET    = 16'd400;
   localparam logic [15:0] REPEAT_RESET  = 16'd200;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [4:0] key_index;
      logic       event_valid;
      logic [3:0] column_drive;
   } result_type;

endpackage : mks_pkg
`default_nettype wire

// File: hdl/matrix_keypad_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix keypad scanner core
// Scans a 4-row keypad, the push-to-talk line and side keys, one tick per
// transaction, and reports pressed / short / long / repeat / released events.
// ----------------------------------------------------------------------------
// Stage 1 registers an accepted tick, stage 2 its result on rsp_.
// Throughput: one tick per cycle unless rsp_ stalls; the phase machine and its
// 16-bit tick counter update once per tick between the input and the result register.
// Reset (synchronous, active high): phase idle, columns driven low, timers
// cleared, registers back to 30 / 30 / 400 / 200 ticks, both stages empty.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_core
   import mks_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   // tick input: [3:0] row_lines, [4] ptt_line, [7:5] zero
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,

   // result: [3:0] column_drive, [4] event_valid, [9:5] key_index, [15:10] zero
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,
   // result kind: [2:0] event_kind
   output      logic [2:0]  rsp_tuser,

   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // ---------------------------------------------------------------- config
   logic [15:0] deb_in_ff, deb_out_ff, long_ff, repeat_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_in_ff  <= DEB_IN_RESET;
         deb_out_ff <= DEB_OUT_RESET;
         long_ff    <= LONG_RESET;
         repeat_ff  <= REPEAT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEB_IN:  deb_in_ff  <= csr_pwdata[15:0];
            REG_DEB_OUT: deb_out_ff <= csr_pwdata[15:0];
            REG_LONG:    long_ff    <= csr_pwdata[15:0];
            REG_REPEAT:  repeat_ff  <= csr_pwdata[15:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DEB_IN:  csr_prdata = {16'd0, deb_in_ff};
         REG_DEB_OUT: csr_prdata = {16'd0, deb_out_ff};
         REG_LONG:    csr_prdata = {16'd0, long_ff};
         REG_REPEAT:  csr_prdata = {16'd0, repeat_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- stages
   // Stage 1 holds the accepted tick, stage 2 the result. The tick is
   // processed (and the state advanced) as it moves from stage 1 to 2.
   logic       in_valid_ff;
   logic [3:0] in_rows_ff;
   logic       in_ptt_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   logic       out_free, advance;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_rows_ff <= req_tdata[3:0];
         in_ptt_ff  <= req_tdata[4];
      end
   end

   // ---------------------------------------------------------------- scanner
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  held_row_ff, held_row_in;
   logic [2:0]  held_col_ff, held_col_in;
   logic [15:0] timer_ff, timer_in;
   logic [3:0]  drive_ff, drive_in;
   logic        ev;
   logic [2:0]  kind;
   logic [15:0] timer_inc;
   logic        done_in, done_out, done_long, done_rep;
   logic        released, row_low;
   logic [2:0]  col_plus1, col_step;
   logic [4:0]  key;
   result_type  result;

   // wrapping tick count; zero after wrap also ends the wait
   assign timer_inc = 16'(timer_ff + 16'd1);
   assign done_in   = (timer_inc >= deb_in_ff)  || (timer_inc == 16'd0);
   assign done_out  = (timer_inc >= deb_out_ff) || (timer_inc == 16'd0);
   assign done_long = (timer_inc >= long_ff)    || (timer_inc == 16'd0);
   assign done_rep  = (timer_inc >= repeat_ff)  || (timer_inc == 16'd0);

   assign row_low  = ~in_rows_ff[held_row_ff[1:0]];
   assign released = (held_row_ff == ROW_IS_PTT) ? in_ptt_ff
                                                 : in_rows_ff[held_row_ff[1:0]];
   assign col_step = (held_col_ff == COL_SIDE_CODE) ? 3'd0
                                                    : {1'b0, 2'(held_col_ff[1:0] + 2'd1)};

   always_comb begin
      phase_in    = phase_ff;
      held_row_in = held_row_ff;
      held_col_in = held_col_ff;
      timer_in    = timer_ff;
      drive_in    = drive_ff;
      ev          = 1'b0;
      kind        = EV_PRESSED;
      case (phase_ff)
         PH_IDLE: begin
            drive_in = 4'd0;
            if (!in_ptt_ff) begin
               held_row_in = ROW_IS_PTT;
               phase_in    = PH_DEB_IN;
               timer_in    = 16'd0;
            end else if (in_rows_ff != 4'hF) begin
               // lowest row wins
               if (!in_rows_ff[0])      held_row_in = 3'd0;
               else if (!in_rows_ff[1]) held_row_in = 3'd1;
               else if (!in_rows_ff[2]) held_row_in = 3'd2;
               else                     held_row_in = 3'd3;
               phase_in = PH_DEB_IN;
               timer_in = 16'd0;
            end
         end
         PH_DEB_IN: begin
            timer_in = timer_inc;
            if (done_in) begin
               timer_in = 16'd0;
               if (held_row_ff == ROW_IS_PTT) begin
                  ev       = 1'b1;
                  kind     = EV_PRESSED;
                  phase_in = PH_HOLD;
               end else begin
                  held_col_in = COL_SIDE_CODE;
                  drive_in    = 4'hF;
                  phase_in    = PH_SCAN;
               end
            end
         end
         PH_SCAN: begin
            if (row_low) begin
               ev       = 1'b1;
               kind     = EV_PRESSED;
               phase_in = PH_HOLD;
               timer_in = 16'd0;
            end else if (held_col_ff == 3'd3) begin
               phase_in = PH_DEB_OUT;
               timer_in = 16'd0;
               drive_in = 4'd0;
            end else begin
               held_col_in = col_step;
               drive_in    = ~(4'd1 << col_step[1:0]);
            end
         end
         PH_HOLD: begin
            if (released) begin
               ev       = 1'b1;
               kind     = EV_SHORT;
               phase_in = PH_DEB_OUT;
               timer_in = 16'd0;
               drive_in = 4'd0;
            end else begin
               timer_in = timer_inc;
               if (done_long) begin
                  ev       = 1'b1;
                  kind     = EV_LONG;
                  phase_in = PH_LONG;
                  timer_in = 16'd0;
               end
            end
         end
         PH_LONG: begin
            if (released) begin
               ev       = 1'b1;
               kind     = EV_RELEASED;
               phase_in = PH_DEB_OUT;
               timer_in = 16'd0;
               drive_in = 4'd0;
            end else begin
               timer_in = timer_inc;
               if (done_rep) begin
                  ev       = 1'b1;
                  kind     = EV_REPEAT;
                  timer_in = 16'd0;
               end
            end
         end
         PH_DEB_OUT: begin
            drive_in = 4'd0;
            timer_in = timer_inc;
            if (done_out) begin
               phase_in = PH_IDLE;
               timer_in = 16'd0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            timer_in = 16'd0;
            drive_in = 4'd0;
         end
      endcase
   end

   // key = (column+1)*4 + row, side column counted as -1
   assign col_plus1 = 3'(held_col_in + 3'd1);
   assign key       = (held_row_in == ROW_IS_PTT) ? KEY_PTT
                                                  : {col_plus1, held_row_in[1:0]};

   always_comb begin
      result.column_drive = drive_in;
      result.event_valid  = ev;
      result.event_kind   = ev ? kind : 3'd0;
      result.key_index    = ev ? key : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         held_row_ff <= 3'd0;
         held_col_ff <= COL_SIDE_CODE;
         timer_ff    <= 16'd0;
         drive_ff    <= 4'd0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         held_row_ff <= held_row_in;
         held_col_ff <= held_col_in;
         timer_ff    <= timer_in;
         drive_ff    <= drive_in;
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.key_index, rsp_ff.event_valid, rsp_ff.column_drive};
   assign rsp_tuser  = rsp_ff.event_kind;

endmodule : matrix_keypad_scanner_core
`default_nettype wire

// File: tb/keypad_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner scoreboard
// Tick-level model of the six scan phases, plus the queue of result
// transactions still due from the block.
// ----------------------------------------------------------------------------
package keypad_scoreboard_pkg;
   import mks_pkg::*;

   localparam logic [2:0] LAST_COLUMN = 3'd3;

   class keypad_scoreboard;
      logic [15:0] deb_in_ticks;
      logic [15:0] deb_out_ticks;
      logic [15:0] long_ticks;
      logic [15:0] repeat_ticks;

      logic [2:0]  phase;
      logic [2:0]  held_row;
      logic [2:0]  held_column;
      logic [15:0] tick_count;
      logic [3:0]  drive;

      result_type  due[$];
      int          errors;
      int          results_seen;

      function new();
         deb_in_ticks  = DEB_IN_RESET;
         deb_out_ticks = DEB_OUT_RESET;
         long_ticks    = LONG_RESET;
         repeat_ticks  = REPEAT_RESET;
         phase         = PH_IDLE;
         held_row      = '0;
         held_column   = COL_SIDE_CODE;
         tick_count    = '0;
         drive         = '0;
         errors        = 0;
         results_seen  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            REG_DEB_IN:  deb_in_ticks  = value;
            REG_DEB_OUT: deb_out_ticks = value;
            REG_LONG:    long_ticks    = value;
            REG_REPEAT:  repeat_ticks  = value;
            default: ;
         endcase
      endfunction

      // counter wraps at 16 bits; a zero limit behaves as one
      function bit timer_expired(logic [15:0] limit);
         tick_count = tick_count + 16'd1;
         return (tick_count >= limit) || (tick_count == 16'd0);
      endfunction

      function void enter_deb_out();
         phase      = PH_DEB_OUT;
         tick_count = '0;
         drive      = '0;
      endfunction

      function logic [4:0] held_key();
         if (held_row == ROW_IS_PTT)
            return KEY_PTT;
         return {held_column + 3'd1, held_row[1:0]};
      endfunction

      function bit held_line_up(logic [3:0] rows, logic ptt);
         if (held_row == ROW_IS_PTT)
            return ptt;
         return rows[held_row[1:0]];
      endfunction

      // advance one scan tick and queue the result it owes
      function void note_tick(logic [3:0] rows, logic ptt);
         result_type r;
         logic       fired;
         logic [2:0] kind;
         int         i;
         fired = 1'b0;
         kind  = '0;
         case (phase)
            PH_IDLE: begin
               drive = '0;
               if (!ptt) begin
                  held_row   = ROW_IS_PTT;
                  phase      = PH_DEB_IN;
                  tick_count = '0;
               end else if (rows != 4'hF) begin
                  i = 0;
                  while (rows[i])
                     i++;
                  held_row   = i[2:0];
                  phase      = PH_DEB_IN;
                  tick_count = '0;
               end
            end
            PH_DEB_IN: begin
               if (timer_expired(deb_in_ticks)) begin
                  tick_count = '0;
                  if (held_row == ROW_IS_PTT) begin
                     fired = 1'b1;
                     kind  = EV_PRESSED;
                     phase = PH_HOLD;
                  end else begin
                     held_column = COL_SIDE_CODE;
                     drive       = 4'hF;
                     phase       = PH_SCAN;
                  end
               end
            end
            PH_SCAN: begin
               if (!rows[held_row[1:0]]) begin
                  fired      = 1'b1;
                  kind       = EV_PRESSED;
                  phase      = PH_HOLD;
                  tick_count = '0;
               end else if (held_column == LAST_COLUMN) begin
                  enter_deb_out();
               end else begin
                  held_column = (held_column == COL_SIDE_CODE) ? 3'd0 : held_column + 3'd1;
                  drive       = ~(4'b0001 << held_column[1:0]);
               end
            end
            PH_HOLD: begin
               if (held_line_up(rows, ptt)) begin
                  fired = 1'b1;
                  kind  = EV_SHORT;
                  enter_deb_out();
               end else if (timer_expired(long_ticks)) begin
                  fired      = 1'b1;
                  kind       = EV_LONG;
                  phase      = PH_LONG;
                  tick_count = '0;
               end
            end
            PH_LONG: begin
               if (held_line_up(rows, ptt)) begin
                  fired = 1'b1;
                  kind  = EV_RELEASED;
                  enter_deb_out();
               end else if (timer_expired(repeat_ticks)) begin
                  fired      = 1'b1;
                  kind       = EV_REPEAT;
                  tick_count = '0;
               end
            end
            PH_DEB_OUT: begin
               drive = '0;
               if (timer_expired(deb_out_ticks)) begin
                  phase      = PH_IDLE;
                  tick_count = '0;
               end
            end
            default: begin
               phase      = PH_IDLE;
               tick_count = '0;
               drive      = '0;
            end
         endcase
         r.column_drive = drive;
         r.event_valid  = fired;
         r.event_kind   = fired ? kind : '0;
         r.key_index    = fired ? held_key() : '0;
         due.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         results_seen++;
         if (due.size() == 0) begin
            report($sformatf("result %0d arrived with nothing due", results_seen));
            return;
         end
         want = due.pop_front();
         if (got.column_drive !== want.column_drive)
            report($sformatf("result %0d column_drive got %h want %h",
                             results_seen, got.column_drive, want.column_drive));
         if (got.event_valid !== want.event_valid)
            report($sformatf("result %0d event_valid got %b want %b",
                             results_seen, got.event_valid, want.event_valid));
         if (got.event_kind !== want.event_kind)
            report($sformatf("result %0d event_kind got %0d want %0d",
                             results_seen, got.event_kind, want.event_kind));
         if (got.key_index !== want.key_index)
            report($sformatf("result %0d key_index got %0d want %0d",
                             results_seen, got.key_index, want.key_index));
      endtask
   endclass

endpackage : keypad_scoreboard_pkg

// File: tb/tb_matrix_keypad_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix keypad scanner testbench
// Drives scan ticks from a small keypad model that reacts to the predicted
// column drive, checks every result transaction against the scoreboard, and
// walks the timing registers through minimum, zero, random, reset and maximum
// settings with random idling and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb_matrix_keypad_scanner_core;
   import mks_pkg::*;
   import keypad_scoreboard_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_SLACK  = 8;        // slack after the last due result is back
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int HOLD_OFF     = 400;      // long receiver stall, fills the pipe

   // one physical key: push-to-talk, a side key or a matrix key
   typedef struct packed {
      logic       is_ptt;
      logic [2:0] column;                  // COL_SIDE_CODE for the side column
      logic [1:0] row;
   } keypad_key_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;                 // [3:0] row_lines, [4] ptt_line, [7:5] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;                 // [3:0] column_drive, [4] event_valid,
                                           // [9:5] key_index, [15:10] zero
   logic [2:0]  rsp_tuser;                 // [2:0] event_kind
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   keypad_scoreboard board;
   keypad_key_type   pressed_keys[$];      // keys currently held down on the pad

   int src_idle_pct;                       // chance of a sender gap before a tick
   int sink_stall_pct;                     // chance of a receiver stall burst
   int sink_hold;                          // one-off long receiver stall, in cycles
   int noise_pct;                          // chance of a random line sample
   int ticks_sent;
   int cycle_count;

   matrix_keypad_scanner_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop. Every edge is counted here, independent of the stimulus.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Result receiver: random stall bursts, plus the one long hold-off that the
   // stimulus asks for. The hold-off is counted out here, in cycles.
   initial begin : result_sink
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock iff (reset === 1'b0));
      forever begin
         if (sink_hold > 0) begin
            stall     = sink_hold;
            sink_hold = 0;
            rsp_tready <= 1'b0;
            while (stall > 0) begin
               @(posedge clock);
               stall--;
            end
         end else if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // All stimulus waits go through here, so a result transaction is checked
   // before the same edge's input transaction is noted: no ordering race.
   task automatic step_clock();
      result_type got;
      @(posedge clock);
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.column_drive = rsp_tdata[3:0];
         got.event_valid  = rsp_tdata[4];
         got.key_index    = rsp_tdata[9:5];
         got.event_kind   = rsp_tuser;
         board.check_result(got);
      end
   endtask

   // One tick transaction: optional gap, then hold valid until accepted.
   task automatic send_tick(input logic [4:0] lines);
      if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) step_clock();
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, lines};
      step_clock();
      while (req_tready !== 1'b1)
         step_clock();
      board.note_tick(lines[3:0], lines[4]);
      ticks_sent++;
   endtask

   // Row and PTT levels the pad shows for the column drive of the last tick.
   // Side keys pull their row low whatever the columns do.
   function automatic logic [4:0] keypad_lines();
      logic [3:0] rows;
      logic       ptt;
      rows = 4'hF;
      ptt  = 1'b1;
      foreach (pressed_keys[k]) begin
         if (pressed_keys[k].is_ptt)
            ptt = 1'b0;
         else if (pressed_keys[k].column == COL_SIDE_CODE ||
                  !board.drive[pressed_keys[k].column[1:0]])
            rows[pressed_keys[k].row] = 1'b0;
      end
      return {ptt, rows};
   endfunction

   task automatic play_ticks(input int n);
      logic [4:0] lines;
      repeat (n) begin
         if (noise_pct > 0 && $urandom_range(99) < noise_pct)
            lines = 5'($urandom_range(31, 0));
         else
            lines = keypad_lines();
         send_tick(lines);
      end
   endtask

   // Keys already in pressed_keys are held for 'hold' ticks, then all let go.
   task automatic hold_and_release(input int hold, input int gap);
      play_ticks(hold);
      pressed_keys.delete();
      play_ticks(gap);
   endtask

   function automatic keypad_key_type make_key(input logic is_ptt,
                                               input logic [2:0] column,
                                               input logic [1:0] row);
      keypad_key_type k;
      k.is_ptt = is_ptt;
      k.column = column;
      k.row    = row;
      return k;
   endfunction

   function automatic keypad_key_type random_key();
      keypad_key_type k;
      k.is_ptt = ($urandom_range(9) == 0);
      k.column = ($urandom_range(4) == 0) ? COL_SIDE_CODE : 3'($urandom_range(3));
      k.row    = 2'($urandom_range(3));
      return k;
   endfunction

   function automatic int reg_ticks(input logic [15:0] value);
      return (value == 16'd0) ? 1 : int'(value);
   endfunction

   // Hold lengths spread over bounces, short presses and long presses with
   // a few repeats, scaled by the current register settings.
   function automatic int pick_hold();
      int din;
      int span;
      din  = reg_ticks(board.deb_in_ticks);
      span = din + 8 + reg_ticks(board.long_ticks) + 3 * reg_ticks(board.repeat_ticks);
      case ($urandom_range(3))
         0:       return $urandom_range(din + 1, 1);
         1:       return $urandom_range(span, din + 6);
         default: return $urandom_range(span, 1);
      endcase
   endfunction

   // Mostly clean key presses with random keys and timing; now and then a
   // second key at once, or a burst of random line samples.
   task automatic random_presses(input int n);
      int start;
      start = ticks_sent;
      while (ticks_sent - start < n) begin
         pressed_keys.delete();
         pressed_keys.push_back(random_key());
         if ($urandom_range(3) == 0)
            pressed_keys.push_back(random_key());
         hold_and_release(pick_hold(),
                          $urandom_range(reg_ticks(board.deb_out_ticks) + 6, 0));
         if ($urandom_range(11) == 0)
            repeat ($urandom_range(6, 1)) send_tick(5'($urandom_range(31, 0)));
      end
   endtask

   // Sender stops and waits until every due result has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.due.size() != 0)
         step_clock();
      repeat (DRAIN_SLACK) step_clock();
   endtask

   task automatic csr_check(input logic [1:0] idx, input logic [15:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      step_clock();
      csr_penable <= 1'b1;
      step_clock();
      if (csr_prdata !== {16'h0000, want})
         board.report($sformatf("register %0d reads %h want %h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      step_clock();
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      step_clock();
      csr_penable <= 1'b1;
      step_clock();
      board.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      step_clock();
      csr_check(idx, value);
   endtask

   // Registers only change with the block drained.
   task automatic set_config(input logic [15:0] din, input logic [15:0] dout,
                             input logic [15:0] lng, input logic [15:0] rpt);
      settle();
      csr_write(REG_DEB_IN, din);
      csr_write(REG_DEB_OUT, dout);
      csr_write(REG_LONG, lng);
      csr_write(REG_REPEAT, rpt);
   endtask

   initial begin : stimulus
      board = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      sink_hold      = 0;
      noise_pct      = 0;
      ticks_sent     = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      step_clock();

      // registers come out of reset at their documented defaults
      csr_check(REG_DEB_IN, DEB_IN_RESET);
      csr_check(REG_DEB_OUT, DEB_OUT_RESET);
      csr_check(REG_LONG, LONG_RESET);
      csr_check(REG_REPEAT, REPEAT_RESET);

      // ---- directed: short timers so every event shows up in a few ticks ----
      set_config(16'd1, 16'd1, 16'd2, 16'd1);
      // push-to-talk wins over a matrix key; long press, repeats, released
      pressed_keys.push_back(make_key(1'b1, 3'd0, 2'd0));
      pressed_keys.push_back(make_key(1'b0, LAST_COLUMN, 2'd0));
      hold_and_release(6, 2);
      // two rows low: the lower row (a side key) is taken; short press
      pressed_keys.push_back(make_key(1'b0, COL_SIDE_CODE, 2'd1));
      pressed_keys.push_back(make_key(1'b0, 3'd1, 2'd2));
      hold_and_release(4, 2);
      // last column found on the final scan step, held into repeats
      pressed_keys.push_back(make_key(1'b0, LAST_COLUMN, 2'd3));
      hold_and_release(11, 2);
      // row bounce: gone before the scan, so the scan finds nothing
      pressed_keys.push_back(make_key(1'b0, 3'd0, 2'd2));
      hold_and_release(1, 7);
      // push-to-talk bounce: no resample at debounce end, still a press
      pressed_keys.push_back(make_key(1'b1, 3'd0, 2'd0));
      hold_and_release(1, 3);
      // everything low at once, then all lines high
      send_tick(5'b00000);
      play_ticks(4);

      // ---- random phases ----
      noise_pct = 4;

      // minimum timers, idling on both sides
      set_config(16'd1, 16'd1, 16'd1, 16'd1);
      src_idle_pct   = 25;
      sink_stall_pct = 25;
      random_presses(250);

      // zero in every register behaves as one
      set_config(16'd0, 16'd0, 16'd0, 16'd0);
      random_presses(150);

      // random short timers, a stretch with no idling at all
      set_config(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                 16'($urandom_range(30, 1)), 16'($urandom_range(10, 1)));
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      random_presses(250);

      // receiver holds off for a long stretch while ticks keep coming
      set_config(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                 16'($urandom_range(30, 1)), 16'($urandom_range(10, 1)));
      src_idle_pct   = 30;
      sink_stall_pct = 30;
      sink_hold      = HOLD_OFF;
      random_presses(250);

      // back to the reset timings
      set_config(DEB_IN_RESET, DEB_OUT_RESET, LONG_RESET, REPEAT_RESET);
      src_idle_pct   = 15;
      sink_stall_pct = 15;
      random_presses(400);

      // maximum timers: a press far shorter than the debounce-in wait, which
      // keeps counting through the release without a scan or an event
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      noise_pct      = 0;
      src_idle_pct   = 2;
      sink_stall_pct = 2;
      pressed_keys.push_back(make_key(1'b0, 3'd2, 2'd1));
      hold_and_release(40, 20);

      // last part: no idling on either side
      set_config(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                 16'($urandom_range(30, 1)), 16'($urandom_range(10, 1)));
      noise_pct      = 4;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      random_presses(250);

      settle();
      if (board.errors == 0 && board.due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule : tb_matrix_keypad_scanner_core
